FILE: sv/dmx_packet_channel_trigger_assert.svh
// Assertion macros used by the RTL file dpct_parse.sv.
`ifndef DMX_PACKET_CHANNEL_TRIGGER_ASSERT_SVH
`define DMX_PACKET_CHANNEL_TRIGGER_ASSERT_SVH

`ifndef SYNTHESIS

`define DPCT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("dpct assertion failed");

`define DPCT_ASSERT_MSG(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

`else

`define DPCT_ASSERT(lbl, prop)

`define DPCT_ASSERT_MSG(lbl, prop, msg)

`endif

`endif

FILE: sv/dpct_pkg.sv
package dpct_pkg;

  localparam logic [1:0] CFG_START_CHANNEL  = 2'd0;
  localparam logic [1:0] CFG_UNIVERSE       = 2'd1;
  localparam logic [1:0] CFG_FIRE_THRESHOLD = 2'd2;

  localparam logic [9:0] START_RESET     = 10'd1;
  localparam logic [15:0] UNIVERSE_RESET = 16'd0;
  localparam logic [7:0] THRESHOLD_RESET = 8'd128;

  // ID bytes, first byte in the lowest bits
  localparam logic [63:0] ART_ID         = 64'h0074_654e_2d74_7241;
  localparam logic [9:0] ART_ID_BYTES    = 10'd8;
  localparam logic [9:0] ART_OP_LO_POS   = 10'd8;
  localparam logic [9:0] ART_OP_HI_POS   = 10'd9;
  localparam logic [9:0] ART_UNIV_LO_POS = 10'd14;
  localparam logic [9:0] ART_UNIV_HI_POS = 10'd15;
  localparam logic [9:0] ART_LEN_HI_POS  = 10'd16;
  localparam logic [9:0] ART_LEN_LO_POS  = 10'd17;
  localparam logic [7:0] ART_OP_LO       = 8'h00;
  localparam logic [7:0] ART_OP_HI       = 8'h50;
  localparam logic [9:0] ACN_UNIV_HI_POS = 10'd113;
  localparam logic [9:0] ACN_UNIV_LO_POS = 10'd114;

  // data offset minus one, added to the one-based start channel
  localparam logic [10:0] ART_BASE_ADJ = 11'd17;
  localparam logic [10:0] ACN_BASE_ADJ = 11'd125;
  localparam logic [10:0] ART_MIN_LEN  = 11'd18;
  localparam logic [10:0] ACN_MIN_LEN  = 11'd126;
  localparam logic [9:0] IDX_MAX       = 10'd1023;

  localparam int OUT_BYTES = 5;

  typedef struct packed {
    logic        start_zero;
    logic [9:0]  start_m1;
    logic [10:0] art_base;
    logic [10:0] acn_base;
    logic [15:0] universe;
    logic [7:0]  threshold;
  } cfg_t;

  typedef struct packed {
    logic        accepted;
    logic [31:0] fire_mask;
  } result_t;

endpackage

FILE: sv/dpct_cfg.sv
module dpct_cfg (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  output dpct_pkg::cfg_t    cfg
);
  import dpct_pkg::*;

  logic [9:0]  start_channel;
  logic [15:0] universe;
  logic [7:0]  fire_threshold;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_channel  <= START_RESET;
      universe       <= UNIVERSE_RESET;
      fire_threshold <= THRESHOLD_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_START_CHANNEL:  start_channel  <= cfg_data[9:0];
        CFG_UNIVERSE:       universe       <= cfg_data;
        CFG_FIRE_THRESHOLD: fire_threshold <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.start_zero = (start_channel == 10'd0);
    cfg.start_m1   = start_channel - 10'd1;
    cfg.art_base   = {1'b0, start_channel} + ART_BASE_ADJ;
    cfg.acn_base   = {1'b0, start_channel} + ACN_BASE_ADJ;
    cfg.universe   = universe;
    cfg.threshold  = fire_threshold;
  end

endmodule

FILE: sv/dpct_parse.sv
`include "dmx_packet_channel_trigger_assert.svh"

module dpct_parse #(
  parameter int CHANNELS         = 32,
  parameter int MAX_PACKET_BYTES = 600
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_valid,
  output logic                s_ready,
  input  logic [7:0]          s_byte,
  input  logic                s_last,
  input  logic                s_sacn,
  input  dpct_pkg::cfg_t      cfg,
  input  logic                out_free,
  output logic                res_load,
  output dpct_pkg::result_t   res
);
  import dpct_pkg::*;

  localparam int MASK_W = (CHANNELS > 32) ? CHANNELS : 32;
  localparam logic [10:0] LEN_MAX = 11'(MAX_PACKET_BYTES);

  logic                in_valid;
  logic [7:0]          in_byte;
  logic                in_last;
  logic                in_sacn;
  logic                advance;

  logic [9:0]          byte_index;
  logic                header_good;
  logic [15:0]         captured_universe;
  logic [15:0]         declared_length;
  logic [CHANNELS-1:0] level_bits;
  logic [CHANNELS-1:0] present_bits;
  logic [CHANNELS-1:0] armed_flags;

  logic [9:0]          byte_index_next;
  logic                header_good_next;
  logic [15:0]         universe_next;
  logic [15:0]         length_next;
  logic [CHANNELS-1:0] level_next;
  logic [CHANNELS-1:0] present_next;
  logic [CHANNELS-1:0] armed_next;
  logic [CHANNELS-1:0] fire;
  logic [CHANNELS-1:0] hit;
  logic [MASK_W-1:0]   fire_wide;

  logic [10:0]         pos_ext;
  logic [10:0]         base;
  logic [10:0]         diff;
  logic [10:0]         pkt_len;
  logic [10:0]         slot_no;
  logic                slot_ok;
  logic                at_level;
  logic                univ_match;
  logic                ok;
  logic                in_len;
  logic                act;

  assign advance  = in_valid && (!in_last || out_free);
  assign s_ready  = !in_valid || advance;
  assign res_load = advance && in_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_ready) begin
      in_valid <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_valid && s_ready) begin
      in_byte <= s_byte;
      in_last <= s_last;
      in_sacn <= s_sacn;
    end
  end

  always_comb begin
    pos_ext  = {1'b0, byte_index};
    base     = in_sacn ? cfg.acn_base : cfg.art_base;
    diff     = pos_ext - base;
    slot_ok  = !cfg.start_zero && (pos_ext >= base) && (diff < 11'(CHANNELS));
    at_level = (in_byte >= cfg.threshold);

    header_good_next = header_good;
    universe_next    = captured_universe;
    length_next      = declared_length;
    if (in_sacn) begin
      if (byte_index == ACN_UNIV_HI_POS) begin
        universe_next = {in_byte, captured_universe[7:0]};
      end else if (byte_index == ACN_UNIV_LO_POS) begin
        universe_next = {captured_universe[15:8], in_byte};
      end
    end else begin
      if (byte_index < ART_ID_BYTES) begin
        if (in_byte != ART_ID[{byte_index[2:0], 3'b000} +: 8]) header_good_next = 1'b0;
      end else if (byte_index == ART_OP_LO_POS) begin
        if (in_byte != ART_OP_LO) header_good_next = 1'b0;
      end else if (byte_index == ART_OP_HI_POS) begin
        if (in_byte != ART_OP_HI) header_good_next = 1'b0;
      end else if (byte_index == ART_UNIV_LO_POS) begin
        universe_next = {captured_universe[15:8], in_byte};
      end else if (byte_index == ART_UNIV_HI_POS) begin
        universe_next = {in_byte, captured_universe[7:0]};
      end else if (byte_index == ART_LEN_HI_POS) begin
        length_next = {in_byte, declared_length[7:0]};
      end else if (byte_index == ART_LEN_LO_POS) begin
        length_next = {declared_length[15:8], in_byte};
      end
    end

    byte_index_next = (byte_index == IDX_MAX) ? byte_index : byte_index + 10'd1;

    pkt_len    = pos_ext + 11'd1;
    univ_match = (universe_next == cfg.universe);
    if (in_sacn) begin
      ok = (pkt_len >= ACN_MIN_LEN) && (pkt_len <= LEN_MAX) && univ_match;
    end else begin
      ok = (pkt_len >= ART_MIN_LEN) && (pkt_len <= LEN_MAX) && header_good_next &&
           univ_match;
    end

    for (int n = 0; n < CHANNELS; n++) begin
      hit[n]          = slot_ok && (diff == 11'(n));
      present_next[n] = present_bits[n] || hit[n];
      level_next[n]   = hit[n] ? at_level : level_bits[n];
      slot_no         = {1'b0, cfg.start_m1} + 11'(n);
      in_len          = in_sacn || ({5'd0, slot_no} < length_next);
      act             = ok && present_next[n] && in_len;
      fire[n]         = act && level_next[n] && !armed_flags[n];
      armed_next[n]   = act ? level_next[n] : armed_flags[n];
    end

    fire_wide     = MASK_W'(fire);
    res.fire_mask = fire_wide[31:0];
    res.accepted  = ok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index        <= '0;
      header_good       <= 1'b1;
      captured_universe <= '0;
      declared_length   <= '0;
      level_bits        <= '0;
      present_bits      <= '0;
      armed_flags       <= '0;
    end else if (advance) begin
      if (in_last) begin
        byte_index        <= '0;
        header_good       <= 1'b1;
        captured_universe <= '0;
        declared_length   <= '0;
        level_bits        <= '0;
        present_bits      <= '0;
        armed_flags       <= armed_next;
      end else begin
        byte_index        <= byte_index_next;
        header_good       <= header_good_next;
        captured_universe <= universe_next;
        declared_length   <= length_next;
        level_bits        <= level_next;
        present_bits      <= present_next;
      end
    end
  end

  `DPCT_ASSERT(a_clear_after_end, res_load |=> (byte_index == '0) && header_good)
  `DPCT_ASSERT_MSG(a_fired_is_armed,
    res_load |=> (($past(fire) & ~armed_flags) == '0), "fired channel not armed")
  `DPCT_ASSERT_MSG(a_reject_keeps_arm,
    res_load && !ok |=> (armed_flags == $past(armed_flags)), "rejected packet changed arm")

endmodule

FILE: sv/dpct_out.sv
module dpct_out (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              load,
  input  dpct_pkg::result_t                 res,
  output logic                              out_free,
  output logic                              m_valid,
  input  logic                              m_ready,
  output logic [dpct_pkg::OUT_BYTES*8-1:0]  m_data
);
  import dpct_pkg::*;

  result_t hold;

  assign out_free = !m_valid || m_ready;
  assign m_data   = {(OUT_BYTES * 8 - $bits(result_t))'(0), hold};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (out_free) begin
      m_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && out_free) begin
      hold <= res;
    end
  end

endmodule

FILE: sv/dmx_packet_channel_trigger.sv
// A packet's last byte is registered in the parser input stage, and its result is
// then registered in the output register. Throughput: one byte per cycle; the input
// stalls only while a last byte waits on a full, unread result register.
// Reset: packet parser state and all armed flags clear; start_channel 1, universe 0,
// fire_threshold 128.
module dmx_packet_channel_trigger #(
  parameter int CHANNELS         = 32,
  parameter int MAX_PACKET_BYTES = 600
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [7:0]                        s_axis_tdata,   // [7:0] data_byte
  input  logic                              s_axis_tlast,   // packet_end
  input  logic                              s_axis_tuser,   // from_sacn
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [31:0] fire_mask, [32] packet_accepted, [39:33] zero
  output logic [dpct_pkg::OUT_BYTES*8-1:0]  m_axis_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [1:0]                        cfg_index,
  input  logic [15:0]                       cfg_data
);
  import dpct_pkg::*;

  cfg_t    cfg;
  result_t res;
  logic    res_load;
  logic    out_free;

  dpct_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  dpct_parse #(
    .CHANNELS         (CHANNELS),
    .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
  ) u_parse (
    .clk      (clk),
    .rst      (rst),
    .s_valid  (s_axis_tvalid),
    .s_ready  (s_axis_tready),
    .s_byte   (s_axis_tdata),
    .s_last   (s_axis_tlast),
    .s_sacn   (s_axis_tuser),
    .cfg      (cfg),
    .out_free (out_free),
    .res_load (res_load),
    .res      (res)
  );

  dpct_out u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (res_load),
    .res      (res),
    .out_free (out_free),
    .m_valid  (m_axis_tvalid),
    .m_ready  (m_axis_tready),
    .m_data   (m_axis_tdata)
  );

endmodule

FILE: verif/tb_dmx_packet_channel_trigger.sv
module tb_dmx_packet_channel_trigger;

  localparam logic [63:0] ART_SIGNATURE = 64'h00_74_65_4e_2d_74_72_41;
  localparam logic [7:0]  ART_OPCODE_LO = 8'h00;
  localparam logic [7:0]  ART_OPCODE_HI = 8'h50;
  localparam int ART_SLOT_AT    = 18;
  localparam int ACN_SLOT_AT    = 126;
  localparam int ACN_UNIV_HI_AT = 113;
  localparam int ACN_UNIV_LO_AT = 114;
  localparam int MAX_BYTES      = 600;
  localparam int NUM_CH         = 32;
  localparam int QUIET_LIMIT    = 2000;
  localparam int NO_CORRUPT     = -1;

  typedef enum {FILL_MIXED, FILL_HIGH, FILL_LOW, FILL_EDGE, FILL_NOISE} slot_fill_e;

  typedef struct packed {
    logic [7:0] data;
    logic       eop;
    logic       sacn;
  } dmx_byte_t;

  typedef struct packed {
    logic        accepted;
    logic [31:0] mask;
  } trigger_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [dpct_pkg::OUT_BYTES*8-1:0] m_axis_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  // register mirror
  logic [9:0]  m_start = 10'd1;
  logic [15:0] m_univ = 16'd0;
  logic [7:0]  m_thr = 8'd128;

  // packet parser mirror
  logic [9:0]  rx_pos = '0;
  bit          rx_hdr_ok = 1'b1;
  logic [15:0] rx_univ = '0;
  logic [15:0] rx_dlen = '0;
  logic [31:0] rx_level = '0;
  logic [31:0] rx_present = '0;
  logic [31:0] armed = '0;

  dmx_byte_t byte_q[$];
  trigger_t  trigger_q[$];
  dmx_byte_t nxt_byte;
  trigger_t  want;

  bit idle_on = 1'b1;
  int src_gap = 0;
  int snk_gap = 0;
  int quiet = 0;
  int errors = 0;
  int bytes_pushed = 0;
  int bytes_taken = 0;
  int packets_sent = 0;
  int n_accepted = 0;
  int n_fires = 0;
  int results_seen = 0;
  int cfg_writes = 0;

  dmx_packet_channel_trigger DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void note_slot(int pos, int ofs, logic [7:0] b);
    int ch;
    ch = pos - ofs - (int'(m_start) - 1);
    if (m_start == 0 || ch < 0 || ch >= NUM_CH) return;
    rx_present[ch] = 1'b1;
    rx_level[ch] = (b >= m_thr);
  endfunction

  function automatic void parse_dmx_byte(logic [7:0] b, logic eop, logic sacn);
    int pos;
    int len;
    bit ok;
    trigger_t t;
    pos = int'(rx_pos);
    if (sacn) begin
      if (pos == ACN_UNIV_HI_AT) rx_univ[15:8] = b;
      else if (pos == ACN_UNIV_LO_AT) rx_univ[7:0] = b;
      note_slot(pos, ACN_SLOT_AT, b);
    end else begin
      if (pos < 8) begin
        if (b != ART_SIGNATURE[8*pos +: 8]) rx_hdr_ok = 1'b0;
      end else if (pos == 8) begin
        if (b != ART_OPCODE_LO) rx_hdr_ok = 1'b0;
      end else if (pos == 9) begin
        if (b != ART_OPCODE_HI) rx_hdr_ok = 1'b0;
      end else if (pos == 14) begin
        rx_univ[7:0] = b;
      end else if (pos == 15) begin
        rx_univ[15:8] = b;
      end else if (pos == 16) begin
        rx_dlen[15:8] = b;
      end else if (pos == 17) begin
        rx_dlen[7:0] = b;
      end
      note_slot(pos, ART_SLOT_AT, b);
    end
    if (rx_pos != 10'h3FF) rx_pos = rx_pos + 10'd1;
    if (!eop) return;

    len = pos + 1;
    if (sacn)
      ok = len >= ACN_SLOT_AT && len <= MAX_BYTES && rx_univ == m_univ;
    else
      ok = len >= ART_SLOT_AT && len <= MAX_BYTES && rx_hdr_ok && rx_univ == m_univ;
    t.accepted = ok;
    t.mask = '0;
    if (ok) begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
        if (rx_present[ch] && (sacn || int'(m_start) - 1 + ch < int'(rx_dlen))) begin
          if (rx_level[ch] && !armed[ch]) begin
            t.mask[ch] = 1'b1;
            armed[ch] = 1'b1;
          end else if (!rx_level[ch] && armed[ch]) begin
            armed[ch] = 1'b0;
          end
        end
      end
      n_accepted++;
      n_fires += $countones(t.mask);
    end
    trigger_q.push_back(t);
    rx_pos = '0;
    rx_hdr_ok = 1'b1;
    rx_univ = '0;
    rx_dlen = '0;
    rx_level = '0;
    rx_present = '0;
  endfunction

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      src_gap = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        parse_dmx_byte(s_axis_tdata, s_axis_tlast, s_axis_tuser);
        bytes_taken++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_gap > 0) begin
          src_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (byte_q.size() != 0) begin
          nxt_byte = byte_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= nxt_byte.data;
          s_axis_tlast <= nxt_byte.eop;
          s_axis_tuser <= nxt_byte.sacn;
          if (idle_on && $urandom_range(0, 11) == 0) src_gap = $urandom_range(1, 9);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      snk_gap = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (trigger_q.size() == 0) begin
          $display("%0t: result with nothing expected, tdata %h", $time, m_axis_tdata);
          errors++;
        end else begin
          want = trigger_q.pop_front();
          if (m_axis_tdata[31:0] !== want.mask) begin
            $display("%0t: fire_mask expected %h actual %h", $time, want.mask,
                     m_axis_tdata[31:0]);
            errors++;
          end
          if (m_axis_tdata[32] !== want.accepted) begin
            $display("%0t: packet_accepted expected %b actual %b", $time, want.accepted,
                     m_axis_tdata[32]);
            errors++;
          end
          if (m_axis_tdata[39:33] !== 7'd0) begin
            $display("%0t: padding expected %h actual %h", $time, 7'd0, m_axis_tdata[39:33]);
            errors++;
          end
        end
      end
      if (snk_gap > 0) begin
        snk_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (idle_on && $urandom_range(0, 5) == 0) snk_gap = $urandom_range(1, 9);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("[dmx_packet_channel_trigger] ERROR");
        $finish;
      end
    end
  end

  function automatic logic [7:0] slot_value(slot_fill_e fill, int idx);
    logic [7:0] below;
    below = (m_thr == 0) ? 8'd0 : m_thr - 8'd1;
    case (fill)
      FILL_HIGH: return 8'hFF;
      FILL_LOW:  return 8'h00;
      FILL_EDGE: return idx[0] ? below : m_thr;
      default: begin
        case ($urandom_range(0, 3))
          0: return m_thr;
          1: return below;
          2: return 8'($urandom_range(0, 255));
          default: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
        endcase
      end
    endcase
  endfunction

  task automatic send_packet(input bit acn, input int len, input logic [15:0] univ,
                             input logic [15:0] dlen, input slot_fill_e fill,
                             input int corrupt_at, input bit mix);
    dmx_byte_t r;
    int ofs;
    ofs = acn ? ACN_SLOT_AT : ART_SLOT_AT;
    for (int pos = 0; pos < len; pos++) begin
      r.data = 8'($urandom_range(0, 255));
      if (fill != FILL_NOISE) begin
        if (pos >= ofs) r.data = slot_value(fill, pos - ofs);
        else if (acn) begin
          if (pos == ACN_UNIV_HI_AT) r.data = univ[15:8];
          else if (pos == ACN_UNIV_LO_AT) r.data = univ[7:0];
        end else if (pos < 8) r.data = ART_SIGNATURE[8*pos +: 8];
        else if (pos == 8) r.data = ART_OPCODE_LO;
        else if (pos == 9) r.data = ART_OPCODE_HI;
        else if (pos == 14) r.data = univ[7:0];
        else if (pos == 15) r.data = univ[15:8];
        else if (pos == 16) r.data = dlen[15:8];
        else if (pos == 17) r.data = dlen[7:0];
      end
      if (pos == corrupt_at) r.data = r.data ^ 8'($urandom_range(1, 255));
      r.eop = (pos == len - 1);
      r.sacn = acn;
      if (mix && !r.eop && $urandom_range(0, 3) == 0) r.sacn = !acn;
      byte_q.push_back(r);
      bytes_pushed++;
    end
    packets_sent++;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      dpct_pkg::CFG_START_CHANNEL:  m_start = val[9:0];
      dpct_pkg::CFG_UNIVERSE:       m_univ = val;
      dpct_pkg::CFG_FIRE_THRESHOLD: m_thr = val[7:0];
      default: ;
    endcase
    cfg_writes++;
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (bytes_pushed != bytes_taken || trigger_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_random_phase(input int min_pkts);
    int pkts;
    int first_byte;
    int kind;
    int base;
    int nslots;
    int len;
    int corrupt;
    bit acn;
    bit mix;
    logic [15:0] u;
    logic [15:0] dl;
    slot_fill_e fill;
    pkts = 0;
    first_byte = bytes_pushed;
    base = (m_start == 0) ? 0 : int'(m_start) - 1;
    while (pkts < min_pkts || bytes_pushed - first_byte < 40) begin
      kind = $urandom_range(0, 99);
      acn = ($urandom_range(0, 3) == 0);
      nslots = base + $urandom_range(0, 40);
      len = acn ? ACN_SLOT_AT + nslots : ART_SLOT_AT + nslots;
      if (len > MAX_BYTES) len = MAX_BYTES;
      u = m_univ;
      dl = 16'(nslots);
      fill = FILL_MIXED;
      corrupt = NO_CORRUPT;
      mix = 1'b0;
      if (kind < 70) begin
        if (!acn && $urandom_range(0, 4) == 0) dl = 16'($urandom_range(0, nslots + 8));
      end else if (kind < 78) begin
        u = u ^ (16'd1 << $urandom_range(0, 15));
      end else if (kind < 84) begin
        acn = 1'b0;
        len = ART_SLOT_AT + nslots;
        if (len > MAX_BYTES) len = MAX_BYTES;
        corrupt = $urandom_range(0, 9);
      end else if (kind < 90) begin
        len = $urandom_range(1, acn ? ACN_SLOT_AT - 1 : ART_SLOT_AT - 1);
      end else if (kind < 94) begin
        mix = 1'b1;
      end else if (kind < 97) begin
        fill = FILL_NOISE;
        len = $urandom_range(1, 40);
        mix = $urandom_range(0, 1);
      end else begin
        dl = 16'($urandom_range(0, 65535));
      end
      send_packet(acn, len, u, dl, fill, corrupt, mix);
      pkts++;
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    send_packet(1'b0, 50, 16'd0, 16'd32, FILL_HIGH, NO_CORRUPT, 1'b0);
    send_packet(1'b0, 50, 16'd0, 16'd32, FILL_HIGH, NO_CORRUPT, 1'b0);
    send_packet(1'b0, 50, 16'd0, 16'd32, FILL_LOW, NO_CORRUPT, 1'b0);
    send_packet(1'b0, 50, 16'd0, 16'd32, FILL_EDGE, NO_CORRUPT, 1'b0);
    send_packet(1'b0, 50, 16'd0, 16'd5, FILL_HIGH, NO_CORRUPT, 1'b0);
    send_packet(1'b0, 20, 16'd0, 16'd32, FILL_LOW, NO_CORRUPT, 1'b0);
    send_packet(1'b0, 18, 16'd0, 16'd0, FILL_HIGH, NO_CORRUPT, 1'b0);
    send_packet(1'b0, 17, 16'd0, 16'd0, FILL_HIGH, NO_CORRUPT, 1'b0);
    send_packet(1'b0, 20, 16'd0, 16'd32, FILL_HIGH, 3, 1'b0);
    send_packet(1'b0, 20, 16'd0, 16'd32, FILL_HIGH, 8, 1'b0);
    send_packet(1'b0, 20, 16'd0, 16'd32, FILL_HIGH, 9, 1'b0);
    send_packet(1'b0, 20, 16'd1, 16'd32, FILL_HIGH, NO_CORRUPT, 1'b0);
    send_packet(1'b1, 158, 16'd0, 16'd0, FILL_HIGH, NO_CORRUPT, 1'b0);
    send_packet(1'b1, 126, 16'd0, 16'd0, FILL_LOW, NO_CORRUPT, 1'b0);
    send_packet(1'b1, 125, 16'd0, 16'd0, FILL_HIGH, NO_CORRUPT, 1'b0);
    send_packet(1'b0, 50, 16'd0, 16'd32, FILL_MIXED, NO_CORRUPT, 1'b1);
    send_packet(1'b1, 1, 16'd0, 16'd0, FILL_NOISE, NO_CORRUPT, 1'b0);
    send_packet(1'b0, 1, 16'd0, 16'd0, FILL_NOISE, NO_CORRUPT, 1'b0);
    wait_drained();

    write_reg(dpct_pkg::CFG_START_CHANNEL, 16'd0);
    send_packet(1'b0, 50, 16'd0, 16'd32, FILL_HIGH, NO_CORRUPT, 1'b0);
    send_packet(1'b1, 130, 16'd0, 16'd0, FILL_HIGH, NO_CORRUPT, 1'b0);
    wait_drained();

    for (int p = 1; p <= 4; p++) begin
      idle_on = (p < 4);
      case (p)
        1: begin
          write_reg(dpct_pkg::CFG_START_CHANNEL, 16'd1);
          write_reg(dpct_pkg::CFG_UNIVERSE, 16'hFFFF);
          write_reg(dpct_pkg::CFG_FIRE_THRESHOLD, 16'd255);
        end
        2: begin
          write_reg(dpct_pkg::CFG_START_CHANNEL, 16'd1);
          write_reg(dpct_pkg::CFG_UNIVERSE, 16'd0);
          write_reg(dpct_pkg::CFG_FIRE_THRESHOLD, 16'd0);
        end
        3: begin
          write_reg(dpct_pkg::CFG_START_CHANNEL, 16'($urandom_range(25, 60)));
          write_reg(dpct_pkg::CFG_UNIVERSE, 16'($urandom_range(0, 65535)));
          write_reg(dpct_pkg::CFG_FIRE_THRESHOLD, 16'($urandom_range(0, 255)));
        end
        default: begin
          write_reg(dpct_pkg::CFG_START_CHANNEL, 16'($urandom_range(1, 24)));
          write_reg(dpct_pkg::CFG_UNIVERSE, 16'($urandom_range(0, 65535)));
          write_reg(dpct_pkg::CFG_FIRE_THRESHOLD, 16'($urandom_range(1, 254)));
        end
      endcase
      run_random_phase(1);
      wait_drained();
    end

    $display("Sent %0d packets (%0d bytes) over %0d register writes.", packets_sent,
             bytes_taken, cfg_writes);
    $display("Checked %0d results: %0d packets accepted, %0d channel triggers.",
             results_seen, n_accepted, n_fires);
    if (errors == 0) begin
      $display("[dmx_packet_channel_trigger] OK");
    end else begin
      $display("[dmx_packet_channel_trigger] ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+sv
sv/dpct_pkg.sv
sv/dpct_cfg.sv
sv/dpct_parse.sv
sv/dpct_out.sv
sv/dmx_packet_channel_trigger.sv
verif/tb_dmx_packet_channel_trigger.sv
